### rtl/ili_pkg.sv
// Shared types and constants for the indexed list insert/delete core.
// Depends on nothing; every other file depends on it.
`default_nettype none
package ili_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int ACT_W      = 3;
	localparam int POS_W      = 7;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = 7;

	localparam logic [ACT_W-1:0] ACT_READ       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_HEAD   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INS_TAIL   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_INS_AT     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef struct packed {
		logic                  shift_up;
		logic                  shift_down;
		logic [CNT_W-1:0]      where;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      rd_pos;
	} ili_cmd_t;

endpackage
`default_nettype wire

### rtl/ili_in_if.sv
// Request channel: valid/ready handshake carrying action, position and value.
// Depends on ili_pkg.
`default_nettype none
interface ili_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [ili_pkg::ACT_W-1:0]            action;
	logic [ili_pkg::POS_W-1:0]            position;
	logic signed [ili_pkg::VALUE_BITS-1:0] item_value;

	modport source(output valid, output action, output position, output item_value,
		input ready);
	modport sink(input valid, input action, input position, input item_value,
		output ready);
endinterface
`default_nettype wire

### rtl/ili_out_if.sv
// Result channel: valid/ready handshake carrying read value, status and count.
// Depends on ili_pkg.
`default_nettype none
interface ili_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ili_pkg::VALUE_BITS-1:0] read_value;
	logic [ili_pkg::STAT_W-1:0]           status;
	logic [ili_pkg::CNT_W-1:0]            count_now;

	modport source(output valid, output read_value, output status, output count_now,
		input ready);
	modport sink(input valid, input read_value, input status, input count_now,
		output ready);
endinterface
`default_nettype wire

### rtl/ili_cell.sv
// One list cell: holds one entry, loads a neighbor or new data on shift,
// gates its entry onto the read bus when addressed. Depends on ili_pkg.
`default_nettype none
module ili_cell (
	input  wire logic                           clk,
	input  wire logic [ili_pkg::CNT_W-1:0]      index,
	input  wire ili_pkg::ili_cmd_t              cmd,
	input  wire logic [ili_pkg::VALUE_BITS-1:0] left,
	input  wire logic [ili_pkg::VALUE_BITS-1:0] right,
	output logic [ili_pkg::VALUE_BITS-1:0]      entry,
	output logic [ili_pkg::VALUE_BITS-1:0]      rd_gated
);
	import ili_pkg::*;

	logic [VALUE_BITS-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (index > cmd.where) begin
				entry_q <= left;
			end else if (index == cmd.where) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.shift_down) begin
			if (index >= cmd.where) begin
				entry_q <= right;
			end
		end
	end

	assign entry    = entry_q;
	assign rd_gated = (index == cmd.rd_pos) ? entry_q : '0;
endmodule
`default_nettype wire

### rtl/indexed_list_insert_delete_core.sv
// Indexed list store: a row of ili_cell entries plus length and result logic.
// Depends on ili_pkg, ili_in_if, ili_out_if and ili_cell.
//
// Usage:
//   req carries one word per request: action, position and item_value.
//   rsp returns exactly one word per request: read_value, status, count_now.
//   A request is decoded in the cycle it is accepted; the cells at and past
//   the insert or delete position shift or load on the same edge that puts
//   the result in the rsp register, so rsp valid rises in the cycle after
//   acceptance. Throughput is one request per cycle while rsp is not
//   stalled, set by the single rsp register that req waits on.
//   When rsp is stalled, the held result stays put and req.ready drops until
//   the result is taken; req.ready is high whenever the rsp register is empty
//   or being emptied in the same cycle.
//   Reset (arst_n low) empties the list and the rsp register at once; cell
//   contents are not cleared and are only read after being written.
//   Reads out of range, deletes out of range and inserts past the length
//   return status 1; inserts into a full store return status 2; both leave
//   the list unchanged. Unused action codes return status 0 and do nothing.
`default_nettype none
module indexed_list_insert_delete_core (
	input  wire logic clk,
	input  wire logic arst_n,
	ili_in_if.sink    req,
	ili_out_if.source rsp
);
	import ili_pkg::*;

	logic [CNT_W-1:0]      length_q;
	logic                  rsp_valid_q;
	logic [VALUE_BITS-1:0] rd_value_q;
	logic [STAT_W-1:0]     status_q;
	logic [CNT_W-1:0]      count_q;

	logic                  accept;
	logic                  is_insert;
	logic [CNT_W-1:0]      pos;
	logic [CNT_W-1:0]      where;
	logic                  pos_in_list;
	logic [STAT_W-1:0]     status_d;
	logic [CNT_W-1:0]      length_d;
	logic [VALUE_BITS-1:0] rd_value_d;
	logic [VALUE_BITS-1:0] rd_bus;
	ili_cmd_t              cmd;

	logic [VALUE_BITS-1:0] entry  [CAPACITY];
	logic [VALUE_BITS-1:0] gated  [CAPACITY];

	assign accept      = req.valid && req.ready;
	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign pos         = CNT_W'(req.position);
	assign pos_in_list = pos < length_q;
	assign is_insert   = (req.action == ACT_INS_HEAD) || (req.action == ACT_INS_TAIL)
		|| (req.action == ACT_INS_AT);

	always_comb begin
		case (req.action)
			ACT_INS_HEAD: where = '0;
			ACT_INS_TAIL: where = length_q;
			default:      where = pos;
		endcase
	end

	always_comb begin
		status_d   = ST_DONE;
		length_d   = length_q;
		rd_value_d = '1;
		cmd.shift_up   = 1'b0;
		cmd.shift_down = 1'b0;
		cmd.where      = where;
		cmd.value      = req.item_value;
		cmd.rd_pos     = pos;
		case (req.action)
			ACT_READ: begin
				if (pos_in_list) begin
					rd_value_d = rd_bus;
				end else begin
					status_d = ST_RANGE;
				end
			end
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
				if (where > length_q) begin
					status_d = ST_RANGE;
				end else if (length_q >= CAP_CNT) begin
					status_d = ST_FULL;
				end else begin
					cmd.shift_up = accept;
					length_d     = length_q + CNT_W'(1);
				end
			end
			ACT_DELETE: begin
				if (pos_in_list) begin
					cmd.shift_down = accept;
					length_d       = length_q - CNT_W'(1);
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [VALUE_BITS-1:0] left_n;
		logic [VALUE_BITS-1:0] right_n;
		if (k == 0) begin : g_first
			assign left_n = req.item_value;
		end else begin : g_mid_l
			assign left_n = entry[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_n = entry[k];
		end else begin : g_mid_r
			assign right_n = entry[k+1];
		end
		ili_cell u_cell (
			.clk      (clk),
			.index    (CNT_W'(k)),
			.cmd      (cmd),
			.left     (left_n),
			.right    (right_n),
			.entry    (entry[k]),
			.rd_gated (gated[k])
		);
	end

	always_comb begin
		rd_bus = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_bus = rd_bus | gated[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				length_q    <= length_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_value_q <= rd_value_d;
			status_q   <= status_d;
			count_q    <= length_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rd_value_q;
	assign rsp.status     = status_q;
	assign rsp.count_now  = count_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= CAP_CNT)
		else $error("list length beyond capacity");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.count_now == length_q)
		else $error("reported count differs from list length");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_insert && status_d == ST_DONE |=>
		length_q == $past(length_q) + CNT_W'(1))
		else $error("accepted insert did not grow the list");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d != ST_DONE |=> length_q == $past(length_q))
		else $error("refused request changed the list length");
`endif
endmodule
`default_nettype wire

### verif/indexed_list_insert_delete_core_tb.sv
// Self-checking bench for indexed_list_insert_delete_core: directed and random
// requests on the req channel, every rsp word checked against a shadow list.
// Depends on ili_pkg, ili_in_if, ili_out_if and the core itself.
`default_nettype none
module indexed_list_insert_delete_core_tb;
	import ili_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_SHOWN   = 20;

	typedef struct packed {
		logic                         drain;
		logic [ACT_W-1:0]             action;
		logic [POS_W-1:0]             position;
		logic signed [VALUE_BITS-1:0] item_value;
	} list_req_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] read_value;
		logic [STAT_W-1:0]            status;
		logic [CNT_W-1:0]             count_now;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ili_in_if  req_ch ();
	ili_out_if rsp_ch ();

	indexed_list_insert_delete_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	list_req_t pending_reqs[$];
	list_req_t cur_req = '0;
	logic      req_valid = 1'b0;
	logic      rsp_ready = 1'b0;

	assign req_ch.valid      = req_valid;
	assign req_ch.action     = cur_req.action;
	assign req_ch.position   = cur_req.position;
	assign req_ch.item_value = cur_req.item_value;
	assign rsp_ch.ready      = rsp_ready;

	list_rsp_t expected_rsp [0:4095];
	int n_total = 1;
	int n_sent = 0;
	int n_recv = 0;
	int err_count = 0;
	int cycles = 0;
	int run_phase;

	assign run_phase = (n_sent * 3) / n_total;

	logic signed [VALUE_BITS-1:0] shadow_list [0:CAPACITY-1];
	int shadow_len = 0;
	int gen_len = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic list_rsp_t apply_request(input list_req_t r);
		list_rsp_t o;
		int where;
		int k;
		o.read_value = '1;
		o.status = ST_DONE;
		case (r.action)
			ACT_READ: begin
				if (int'(r.position) < shadow_len)
					o.read_value = shadow_list[r.position];
				else
					o.status = ST_RANGE;
			end
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
				where = (r.action == ACT_INS_HEAD) ? 0 :
					(r.action == ACT_INS_TAIL) ? shadow_len : int'(r.position);
				if (where > shadow_len)
					o.status = ST_RANGE;
				else if (shadow_len >= CAPACITY)
					o.status = ST_FULL;
				else begin
					for (k = shadow_len; k > where; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[where] = r.item_value;
					shadow_len++;
				end
			end
			ACT_DELETE: begin
				if (int'(r.position) < shadow_len) begin
					for (k = int'(r.position); k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
				end else
					o.status = ST_RANGE;
			end
			default: ;
		endcase
		o.count_now = CNT_W'(shadow_len);
		return o;
	endfunction

	task automatic push_req(input logic [ACT_W-1:0] a, input int p,
		input logic signed [VALUE_BITS-1:0] v, input logic d);
		list_req_t r;
		int where;
		r.drain = d;
		r.action = a;
		r.position = POS_W'(p);
		r.item_value = v;
		pending_reqs.push_back(r);
		case (a)
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
				where = (a == ACT_INS_HEAD) ? 0 : (a == ACT_INS_TAIL) ? gen_len : p;
				if (where <= gen_len && gen_len < CAPACITY)
					gen_len++;
			end
			ACT_DELETE: begin
				if (p < gen_len)
					gen_len--;
			end
			default: ;
		endcase
	endtask

	function automatic logic signed [VALUE_BITS-1:0] rand_word();
		logic signed [VALUE_BITS-1:0] w;
		w = VALUE_BITS'($urandom);
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(3))
				0: w = {1'b1, {(VALUE_BITS-1){1'b0}}};
				1: w = {1'b0, {(VALUE_BITS-1){1'b1}}};
				2: w = '1;
				default: w = '0;
			endcase
		end
		return w;
	endfunction

	task automatic build_stimulus();
		logic [ACT_W-1:0] a;
		int p;
		int b;
		int i;
		int mode;
		int roll;
		int ins_pct;
		int del_pct;
		// empty list, then a short known list
		push_req(ACT_READ, 0, '0, 1'b0);
		push_req(ACT_READ, CAPACITY, '0, 1'b0);
		push_req(ACT_DELETE, 0, '0, 1'b0);
		push_req(ACT_INS_AT, 1, 32'h1234_5678, 1'b0);
		push_req(ACT_INS_HEAD, 0, 32'h8000_0000, 1'b0);
		push_req(ACT_INS_TAIL, 0, 32'h7FFF_FFFF, 1'b0);
		push_req(ACT_INS_AT, 2, 32'h0000_0000, 1'b0);
		push_req(ACT_INS_AT, 0, 32'hFFFF_FFFF, 1'b0);
		push_req(ACT_INS_AT, 2, 32'h5555_5555, 1'b0);
		push_req(ACT_INS_AT, CAPACITY, 32'hAAAA_AAAA, 1'b0);
		for (i = 0; i < 6; i++)
			push_req(ACT_READ, i, 32'hAAAA_AAAA, 1'b0);
		push_req(ACT_DELETE, 4, '0, 1'b0);
		push_req(ACT_DELETE, 0, '0, 1'b0);
		push_req(ACT_DELETE, 1, '0, 1'b0);
		for (i = int'(ACT_DELETE) + 1; i < (1 << ACT_W); i++)
			push_req(ACT_W'(i), i, 32'hAAAA_AAAA, 1'b0);
		push_req(ACT_READ, CAPACITY, '0, 1'b0);
		push_req(ACT_DELETE, CAPACITY, '0, 1'b0);
		push_req(ACT_READ, 1, '0, 1'b0);

		// fill to capacity, then poke the full store
		i = 0;
		while (gen_len < CAPACITY) begin
			a = ACT_W'($urandom_range(int'(ACT_INS_HEAD), int'(ACT_INS_AT)));
			push_req(a, $urandom_range(0, gen_len), rand_word(), i == 0);
			i++;
		end
		push_req(ACT_INS_HEAD, 0, rand_word(), 1'b0);
		push_req(ACT_INS_TAIL, 0, rand_word(), 1'b0);
		push_req(ACT_INS_AT, CAPACITY, rand_word(), 1'b0);
		push_req(ACT_INS_AT, 0, rand_word(), 1'b0);
		push_req(ACT_READ, CAPACITY - 1, '0, 1'b0);
		push_req(ACT_READ, CAPACITY, '0, 1'b0);
		push_req(ACT_DELETE, CAPACITY - 1, '0, 1'b0);

		for (b = 0; b < 12; b++) begin
			mode = b % 3;
			ins_pct = (mode == 0) ? 75 : (mode == 1) ? 40 : 15;
			del_pct = (mode == 0) ? 8 : (mode == 1) ? 30 : 60;
			for (i = 0; i < 120; i++) begin
				roll = $urandom_range(99);
				if (roll < 3)
					a = ACT_W'($urandom_range(int'(ACT_DELETE) + 1, (1 << ACT_W) - 1));
				else if (roll < 3 + ins_pct)
					a = ACT_W'($urandom_range(int'(ACT_INS_HEAD), int'(ACT_INS_AT)));
				else if (roll < 3 + ins_pct + del_pct)
					a = ACT_DELETE;
				else
					a = ACT_READ;
				if ($urandom_range(99) < 12)
					p = $urandom_range(0, CAPACITY);
				else if (a == ACT_INS_HEAD || a == ACT_INS_TAIL || a == ACT_INS_AT)
					p = $urandom_range(0, gen_len);
				else
					p = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
				push_req(a, p, rand_word(), i == 0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : req_driver
		logic took;
		int idle_pct;
		if (!arst_n) begin
			req_valid <= 1'b0;
			n_sent <= 0;
		end else begin
			took = req_valid && req_ch.ready;
			idle_pct = (run_phase == 0) ? 17 : (run_phase == 1) ? 76 : 0;
			if (took) begin
				expected_rsp[n_sent] = apply_request(cur_req);
				n_sent <= n_sent + 1;
			end
			if (took || !req_valid) begin
				if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain && (took || n_recv != n_sent)) &&
					$urandom_range(99) >= idle_pct) begin
					cur_req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else
					req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		list_rsp_t want;
		int stall_pct;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			n_recv <= 0;
		end else begin
			stall_pct = (run_phase == 0) ? 76 : (run_phase == 1) ? 17 : 0;
			if (rsp_ch.valid && rsp_ready) begin
				if (n_recv >= n_sent) begin
					err_count <= err_count + 1;
					if (err_count < MAX_SHOWN)
						$display("%0t unexpected word: expected none, actual %0d/%0d/%0d",
							$time, rsp_ch.read_value, rsp_ch.status, rsp_ch.count_now);
				end else begin
					want = expected_rsp[n_recv];
					if (rsp_ch.read_value !== want.read_value ||
						rsp_ch.status !== want.status ||
						rsp_ch.count_now !== want.count_now) begin
						err_count <= err_count + 1;
						if (err_count < MAX_SHOWN)
							$display("%0t word %0d: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
								$time, n_recv, want.read_value, want.status, want.count_now,
								rsp_ch.read_value, rsp_ch.status, rsp_ch.count_now);
					end
					n_recv <= n_recv + 1;
				end
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		n_total = pending_reqs.size();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (n_sent == n_total);
		wait (n_recv == n_total);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
